FILE: hw/rtl/tdpf_pkg.sv
// tdpf_pkg: shared types and constants of the trial-division prime filter
// no dependencies; used by tdpf_rem and trial_division_prime_filter_unit
package tdpf_pkg;

    // width of the tested value, two's complement
    localparam int VALUE_W = 32;
    // width of the step counter of the remainder unit
    localparam int STEP_W  = $clog2(VALUE_W);

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_element;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] tested_value;
        logic                      is_prime;
        logic                      last_result;
    } t_out_item;

    // quotient and remainder handed back by the remainder unit
    typedef struct packed {
        logic [VALUE_W-1:0] quotient;
        logic [VALUE_W-1:0] remainder;
    } t_div_res;

endpackage

FILE: hw/rtl/tdpf_rem.sv
// tdpf_rem: restoring radix-2 divider, one subtract-compare per cycle
// depends on tdpf_pkg (VALUE_W, STEP_W, t_div_res)
module tdpf_rem (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_go,
    input  logic [tdpf_pkg::VALUE_W-1:0]   i_dividend,
    input  logic [tdpf_pkg::VALUE_W-1:0]   i_divisor,
    output logic                           o_done,
    output tdpf_pkg::t_div_res             o_res
);
    import tdpf_pkg::*;

    logic [VALUE_W-1:0] r_rem;
    logic [VALUE_W-1:0] r_quo;
    logic [VALUE_W-1:0] r_dvs;
    logic [STEP_W-1:0]  r_cnt;
    logic               r_run;
    logic               r_done;

    logic [VALUE_W-1:0] w_rem_sh;
    logic [VALUE_W:0]   w_diff;
    logic               w_fit;

    // shift in the next dividend bit and try one subtraction
    assign w_rem_sh = {r_rem[VALUE_W-2:0], r_quo[VALUE_W-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {1'b0, r_dvs};
    assign w_fit    = !w_diff[VALUE_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_run && (r_cnt == '0);
            if (i_go) begin
                r_run <= 1'b1;
            end else if (r_run && (r_cnt == '0)) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
            r_cnt <= STEP_W'(VALUE_W - 1);
        end else if (r_run) begin
            r_rem <= w_fit ? w_diff[VALUE_W-1:0] : w_rem_sh;
            r_quo <= {r_quo[VALUE_W-2:0], w_fit};
            r_cnt <= r_cnt - STEP_W'(1);
        end
    end

    assign o_done          = r_done;
    assign o_res.quotient  = r_quo;
    assign o_res.remainder = r_rem;

endmodule

FILE: hw/rtl/trial_division_prime_filter_unit.sv
// trial_division_prime_filter_unit: top level of the trial-division prime filter
// depends on tdpf_pkg and tdpf_rem
//
//  channel  | ports                      | direction | handshake
//  ---------+----------------------------+-----------+------------------------------
//  input    | start, busy, i_item        | in        | taken when start && !busy
//  result   | o_strobe, o_result         | out       | one cycle per result, no stall
//
//  a value of 1 or less (negative included) gives its result in the cycle after
//  acceptance; otherwise the trial divisors 2, 3, 4 and on take turns in the
//  shared remainder unit until one divides n or d*d exceeds n
//  busy (never raised for 1 or less) stays high from acceptance until the
//  result strobe; the strobe cycle itself already accepts the next transaction
//  reset (synchronous, active low) clears the sequencer and the strobe
//  the receiver cannot stall: every result shows for exactly one cycle
module trial_division_prime_filter_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  tdpf_pkg::t_in_item   i_item,
    output logic                 o_strobe,
    output tdpf_pkg::t_out_item  o_result
);
    import tdpf_pkg::*;

    // one-hot sequencer
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state             r_state, n_state;
    t_in_item           r_item,  n_item;
    logic [VALUE_W-1:0] r_d,     n_d;
    logic               r_strobe, n_strobe;
    t_out_item          r_result, n_result;

    logic               w_accept;
    logic               w_cand;
    logic               w_div_go;
    logic [VALUE_W-1:0] w_div_dvd;
    logic [VALUE_W-1:0] w_div_dvs;
    logic               w_div_done;
    t_div_res           w_div_res;

    // transaction taken this edge
    assign w_accept = start && !busy;
    // only values of 2 and above go to the divisor loop
    assign w_cand   = !i_item.value[VALUE_W-1] &&
                      ($unsigned(i_item.value) > VALUE_W'(1));

    // shared remainder unit: n / d and n % d for the current trial divisor
    tdpf_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (w_div_go),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_done     (w_div_done),
        .o_res      (w_div_res)
    );

    // first divisor is 2, later ones follow the current one
    assign w_div_dvd = (r_state == ST_IDLE) ? $unsigned(i_item.value)
                                            : $unsigned(r_item.value);
    assign w_div_dvs = (r_state == ST_IDLE) ? VALUE_W'(2) : r_d + VALUE_W'(1);

    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_d      = r_d;
        n_strobe = 1'b0;
        n_result = r_result;
        w_div_go = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_item = i_item;
                    if (w_cand) begin
                        // start the loop with divisor 2
                        n_d      = VALUE_W'(2);
                        w_div_go = 1'b1;
                        n_state  = ST_RUN;
                    end else begin
                        // 1 or less is never prime
                        n_strobe              = 1'b1;
                        n_result.tested_value = i_item.value;
                        n_result.is_prime     = 1'b0;
                        n_result.last_result  = i_item.last_element;
                    end
                end
            end
            ST_RUN: begin
                if (w_div_done) begin
                    n_result.tested_value = r_item.value;
                    n_result.last_result  = r_item.last_element;
                    // priority: bound test first, then the remainder
                    priority if (w_div_res.quotient < r_d) begin
                        // d*d > n: no divisor found, prime
                        n_strobe          = 1'b1;
                        n_result.is_prime = 1'b1;
                        n_state           = ST_IDLE;
                    end else if (w_div_res.remainder == '0) begin
                        // exact divisor: composite
                        n_strobe          = 1'b1;
                        n_result.is_prime = 1'b0;
                        n_state           = ST_IDLE;
                    end else begin
                        // try the next divisor
                        n_d      = w_div_dvs;
                        w_div_go = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_d      <= n_d;
        r_result <= n_result;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

`ifndef NO_ASSERTIONS
    // a trial divisor is always at least 2 while the loop runs
    a_div_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_d >= VALUE_W'(2)))
        else $error("trial divisor below 2 during loop");

    // the remainder unit only finishes while the loop waits for it
    a_done_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_RUN))
        else $error("divider done outside the loop");

    // leaving the loop always delivers a result
    a_exit_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RUN) && (n_state == ST_IDLE)) |=> o_strobe)
        else $error("loop ended without a result");

    // a prime flag never goes with a negative value
    a_prime_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.is_prime) |-> !o_result.tested_value[VALUE_W-1])
        else $error("negative value flagged prime");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking testbench of trial_division_prime_filter_unit
// depends on tdpf_pkg and the filter rtl; holds its own primality predictor

module tb_top;

    import tdpf_pkg::*;

    // generous cycle limit, well above the run time of the largest prime
    localparam int CYCLE_LIMIT  = 12_000_000;
    // cycles to watch for stray strobes once nothing is pending
    localparam int DRAIN_CYCLES = 20;

    // primality predictor and the queue of verdicts still due from the block
    class prime_flag_checker;
        t_out_item due_verdicts[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        // trial division with the bound written as d <= n / d so it cannot overflow
        static function t_out_item predict_primality(t_in_item elem);
            t_out_item   verdict;
            logic [63:0] mag;
            logic [63:0] div;
            logic        prime;
            verdict.tested_value = elem.value;
            verdict.last_result  = elem.last_element;
            prime = 1'b0;
            // negative, zero and one are never prime
            if (!elem.value[VALUE_W-1] && elem.value > 1) begin
                mag = '0;
                mag[VALUE_W-1:0] = elem.value;
                prime = 1'b1;
                for (div = 2; div <= mag / div; div++) begin
                    if (mag % div == 0) begin
                        prime = 1'b0;
                        break;
                    end
                end
            end
            verdict.is_prime = prime;
            return verdict;
        endfunction

        function void note_element(t_in_item elem);
            due_verdicts.push_back(predict_primality(elem));
        endfunction

        function void check_verdict(t_out_item got);
            t_out_item want;
            if (due_verdicts.size() == 0) begin
                $display("%0t: result with nothing pending, value %0d prime %0b last %0b",
                         $time, got.tested_value, got.is_prime, got.last_result);
                errors++;
                return;
            end
            want = due_verdicts.pop_front();
            if (got.tested_value !== want.tested_value) begin
                $display("%0t: tested_value mismatch, expected %0d actual %0d",
                         $time, want.tested_value, got.tested_value);
                errors++;
            end
            if (got.is_prime !== want.is_prime) begin
                $display("%0t: is_prime mismatch for %0d, expected %0b actual %0b",
                         $time, want.tested_value, want.is_prime, got.is_prime);
                errors++;
            end
            if (got.last_result !== want.last_result) begin
                $display("%0t: last_result mismatch for %0d, expected %0b actual %0b",
                         $time, want.tested_value, want.last_result, got.last_result);
                errors++;
            end
        endfunction

        function int pending();
            return due_verdicts.size();
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  elem_item;
    logic      o_strobe;
    t_out_item verdict;

    prime_flag_checker verdicts;
    int                sender_idle_pct;
    longint            cycle_count;

    trial_division_prime_filter_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (elem_item),
        .o_strobe (o_strobe),
        .o_result (verdict)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog: a hung block ends the run here
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d verdicts pending", $time, verdicts.pending());
            $display("Verification failed");
            $finish;
        end
    end

    // result monitor: the block cannot be stalled, so every strobe is a transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            verdicts.check_verdict(verdict);
        end
    end

    function automatic t_in_item make_element(logic signed [VALUE_W-1:0] value,
                                              logic last);
        t_in_item elem;
        elem.value        = value;
        elem.last_element = last;
        return elem;
    endfunction

    // one input transaction: optional idle cycles, then start held until busy is low
    task automatic send_element(input t_in_item elem);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start     <= 1'b1;
        elem_item <= elem;
        // accepted at the first rising edge that sees busy low
        do @(posedge i_clk); while (busy !== 1'b0);
        verdicts.note_element(elem);
    endtask

    // random elements, weighted toward cheap values so the run stays short
    task automatic send_random_elements(input int count);
        logic signed [VALUE_W-1:0] value;
        int                        pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                // small values: dense in primes, short trial loops
                value = $urandom_range(3000, 0);
            end else if (pick < 65) begin
                // medium values: longer loops
                value = $urandom_range(200000, 3000);
            end else if (pick < 85) begin
                // negative: answered at once, toggles all low bits
                value = $urandom() | 32'h8000_0000;
            end else begin
                // large even positives: first divisor already hits
                value = $urandom() & 32'h7FFF_FFFE;
            end
            send_element(make_element(value, ($urandom_range(7) == 0)));
        end
    endtask

    initial begin
        verdicts        = new();
        sender_idle_pct = 0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        elem_item       = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: the sub-two cases, small primes, prime squares where the
        // bound is met exactly, and both ends of the range
        send_element(make_element(0, 1'b0));
        send_element(make_element(1, 1'b0));
        send_element(make_element(-1, 1'b1));
        send_element(make_element(2, 1'b0));
        send_element(make_element(3, 1'b0));
        send_element(make_element(4, 1'b1));
        send_element(make_element(9, 1'b0));
        send_element(make_element(25, 1'b0));
        send_element(make_element(49, 1'b0));
        send_element(make_element(97, 1'b0));
        send_element(make_element(121, 1'b0));
        send_element(make_element(8191, 1'b0));
        send_element(make_element(1000001, 1'b0));
        send_element(make_element(1000003, 1'b1));
        send_element(make_element(-2, 1'b0));
        send_element(make_element(32'sh8000_0000, 1'b1));
        send_element(make_element(32'sh8000_0001, 1'b0));
        send_element(make_element(2147483645, 1'b0));
        send_element(make_element(2147483646, 1'b0));
        // square of 46340, right at the divisor bound near the top
        send_element(make_element(2147395600, 1'b0));
        // largest positive value, a prime: the longest trial loop of the run
        send_element(make_element(32'sh7FFF_FFFF, 1'b1));

        // random part in three idling phases
        sender_idle_pct = 27;
        send_random_elements(27);
        sender_idle_pct = 59;
        send_random_elements(26);
        sender_idle_pct = 0;
        send_random_elements(26);

        @(negedge i_clk);
        start <= 1'b0;

        // wait for the last verdict, then watch a little longer for strays
        while (verdicts.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (verdicts.errors == 0 && verdicts.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/tdpf_pkg.sv
hw/rtl/tdpf_rem.sv
hw/rtl/trial_division_prime_filter_unit.sv
tb/tb_top.sv
